[sv/rpchdr_pkg.sv]
// rpchdr_pkg: types and constants for the rpc reply header checker
// no dependencies; imported by rpchdr_fsm and rpc_reply_header_check

package rpchdr_pkg;

  // verdict codes on the status port
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_REPLY = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_BAD_AUTH  = 3'd3,
    ST_AUTH_LONG = 3'd4,
    ST_FAILED    = 3'd5
  } status_e;

  // protocol field values
  localparam logic [31:0] MSG_REPLY      = 32'd1;
  localparam logic [31:0] REPLY_ACCEPTED = 32'd0;
  localparam logic [31:0] FLAVOR_NULL    = 32'd0;
  localparam logic [31:0] FLAVOR_UNIX    = 32'd1;
  localparam logic [31:0] FLAVOR_SHORT   = 32'd2;
  localparam logic [31:0] ACCEPT_SUCCESS = 32'd0;

  localparam int unsigned AuthW    = 10;
  localparam int unsigned OffsetW  = 9;
  localparam int unsigned SkipW    = 8;

  localparam logic [AuthW-1:0] MAX_AUTH_RESET = 10'd400;

  // verdict from one parse step
  typedef struct packed {
    logic                hit;
    status_e             status;
    logic [OffsetW-1:0]  offset;
  } verdict_t;

endpackage

[sv/rpchdr_fsm.sv]
// rpchdr_fsm: header field sequencer, one word per step
// depends on rpchdr_pkg

module rpchdr_fsm import rpchdr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              first_i,
  input  logic [31:0]       word_i,
  input  logic [AuthW-1:0]  max_auth_i,
  output verdict_t          verdict_o,
  output logic [31:0]       xid_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MTYPE,
    PH_RSTAT,
    PH_FLAVOR,
    PH_LEN,
    PH_SKIP,
    PH_ACCEPT
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [SkipW-1:0]    skip_left_q, skip_left_d;
  logic [OffsetW-1:0]  word_index_q, word_index_d;
  logic [31:0]         saved_xid_q, saved_xid_d;
  logic [OffsetW-1:0]  idx_inc;
  logic [OffsetW-1:0]  len_words;
  verdict_t            res;

  assign idx_inc = word_index_q + OffsetW'(1);
  // length is at most 1023 here, so the word count fits in 9 bits
  assign len_words = OffsetW'(({1'b0, word_i[AuthW-1:0]} + 11'd3) >> 2);

  always_comb begin
    phase_d      = phase_q;
    skip_left_d  = skip_left_q;
    word_index_d = word_index_q;
    saved_xid_d  = saved_xid_q;
    res.hit      = 1'b0;
    res.status   = ST_OK;
    res.offset   = '0;
    if (first_i) begin
      saved_xid_d  = word_i;
      word_index_d = '0;
      skip_left_d  = '0;
      phase_d      = PH_MTYPE;
    end else if (phase_q != PH_IDLE) begin
      word_index_d = idx_inc;
      unique case (phase_q)
        PH_MTYPE: begin
          if (word_i != MSG_REPLY) begin
            res.hit = 1'b1;
            res.status = ST_NOT_REPLY;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_RSTAT;
          end
        end
        PH_RSTAT: begin
          if (word_i != REPLY_ACCEPTED) begin
            res.hit = 1'b1;
            res.status = ST_REJECTED;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_FLAVOR;
          end
        end
        PH_FLAVOR: begin
          if (word_i != FLAVOR_NULL && word_i != FLAVOR_UNIX && word_i != FLAVOR_SHORT) begin
            res.hit = 1'b1;
            res.status = ST_BAD_AUTH;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (word_i > {22'd0, max_auth_i}) begin
            res.hit = 1'b1;
            res.status = ST_AUTH_LONG;
            phase_d = PH_IDLE;
          end else if (len_words == '0) begin
            phase_d = PH_ACCEPT;
          end else begin
            skip_left_d = SkipW'(len_words - OffsetW'(1));
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_left_q == '0) begin
            phase_d = PH_ACCEPT;
          end else begin
            skip_left_d = skip_left_q - SkipW'(1);
          end
        end
        PH_ACCEPT: begin
          res.hit = 1'b1;
          phase_d = PH_IDLE;
          if (word_i != ACCEPT_SUCCESS) begin
            res.status = ST_FAILED;
          end else begin
            res.offset = idx_inc + OffsetW'(1);
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      skip_left_q  <= '0;
      word_index_q <= '0;
      saved_xid_q  <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      skip_left_q  <= skip_left_d;
      word_index_q <= word_index_d;
      saved_xid_q  <= saved_xid_d;
    end
  end

  assign verdict_o = res;
  assign xid_o     = saved_xid_q;

endmodule

[sv/rpc_reply_header_check.sv]
// rpc_reply_header_check: top level, input register, sequencer and result register
// depends on rpchdr_pkg and rpchdr_fsm
//
//   channel | dir | handshake                | payload
//   in      | in  | in_valid_i / in_stall_o  | in_first_i, in_word_i
//   out     | out | out_valid_o / out_stall_i| out_status_o, out_xid_o, out_body_offset_o
//   cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_data_i (max_auth_bytes)
//
// one word per cycle sustained while the result is not stalled; a word passes
// the input register, then field compare and counter update in the sequencer
// land the verdict in the result register. reset clears the sequencer to idle,
// empties both registers and loads 400 as the auth limit. a stalled result
// holds the sequencer; in_stall_o rises only while the input register is full
// and cannot drain.

module rpc_reply_header_check import rpchdr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_first_i,
  input  logic [31:0]        in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic [31:0]        out_xid_o,
  output logic [OffsetW-1:0] out_body_offset_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [AuthW-1:0]   cfg_data_i
);

  logic               s1_valid_q;
  logic               s1_first_q;
  logic [31:0]        s1_word_q;
  logic [AuthW-1:0]   max_auth_q;
  logic               out_free;
  logic               step;
  logic               in_fire;
  verdict_t           verdict;
  logic [31:0]        fsm_xid;
  status_e            status_q;
  logic [31:0]        xid_q;
  logic [OffsetW-1:0] offset_q;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_auth_q <= MAX_AUTH_RESET;
    end else if (cfg_valid_i) begin
      max_auth_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q <= in_first_i;
      s1_word_q  <= in_word_i;
    end
  end

  rpchdr_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .first_i    (s1_first_q),
    .word_i     (s1_word_q),
    .max_auth_i (max_auth_q),
    .verdict_o  (verdict),
    .xid_o      (fsm_xid)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= step && verdict.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && verdict.hit) begin
      status_q <= verdict.status;
      xid_q    <= fsm_xid;
      offset_q <= verdict.offset;
    end
  end

  assign out_status_o      = status_q;
  assign out_xid_o         = xid_q;
  assign out_body_offset_o = offset_q;

`ifndef NO_ASSERTIONS
  a_offset_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != ST_OK |-> out_body_offset_o == '0)
    else $error("nonzero body offset on failed verdict");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o <= ST_FAILED)
    else $error("status code out of range");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o)
    else $error("input stalled with room downstream");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> max_auth_q == $past(cfg_data_i))
    else $error("auth limit not loaded");

  a_start_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_first_q |=> !out_valid_o)
    else $error("verdict from a start word");
`endif

endmodule
